// File: hdl/rnsh_pkg.sv
// Package for the nearest ray/segment hit block: types, codes and constants
// shared by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
package rnsh_pkg;

   localparam int MAX_EDGES_DEF  = 256;
   localparam int COORD_BITS_DEF = 16;
   localparam int IN_W           = 16;
   localparam int END_W          = 24;
   localparam int PARAM_W        = 32;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_CAST  = 2'd2;

   localparam logic signed [END_W-1:0] END_MAX = 24'sh7FFFFF;
   localparam logic signed [END_W-1:0] END_MIN = 24'sh800000;
   localparam logic [PARAM_W-1:0]      T_ONE   = 32'h0001_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAST_RD,
      ST_CAST_SUB,
      ST_CAST_MUL,
      ST_CAST_NORM,
      ST_CAST_PP,
      ST_CAST_CMP,
      ST_FIN_MUL,
      ST_FIN_LOAD,
      ST_FIN_RUN,
      ST_FIN_STORE,
      ST_FIN_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_T
   } div_sel_type;

   typedef struct packed {
      logic        load_edge;
      logic        clear_table;
      logic        load_ray;
      logic        rd;
      logic        sub;
      logic        mul;
      logic        norm;
      logic        pp;
      logic        cmp;
      logic        fin_mul;
      logic        fin_load;
      logic        fin_run;
      logic        fin_store;
      logic        out_load;
      div_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic table_empty;
      logic last_edge;
      logic found;
      logic div_last;
   } status_type;

endpackage

// File: hdl/rnsh_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on rnsh_pkg for field widths.
`timescale 1ns / 1ps
interface rnsh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           mode;
   logic signed [rnsh_pkg::IN_W-1:0]     start_x;
   logic signed [rnsh_pkg::IN_W-1:0]     start_y;
   logic signed [rnsh_pkg::IN_W-1:0]     dir_x;
   logic signed [rnsh_pkg::IN_W-1:0]     dir_y;

   modport source (output valid, mode, start_x, start_y, dir_x, dir_y, input ready);
   modport sink   (input valid, mode, start_x, start_y, dir_x, dir_y, output ready);
endinterface

interface rnsh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [rnsh_pkg::END_W-1:0]    end_x;
   logic signed [rnsh_pkg::END_W-1:0]    end_y;
   logic [rnsh_pkg::PARAM_W-1:0]         hit_param;

   modport source (output valid, hit, end_x, end_y, hit_param, input ready);
   modport sink   (input valid, hit, end_x, end_y, hit_param, output ready);
endinterface

// File: hdl/rnsh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rnsh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/rnsh_ctrl.sv
// Controller state machine: sequences table updates, the per-edge walk and
// the three final divisions. Depends on rnsh_pkg.
`timescale 1ns / 1ps
module rnsh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_mode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rnsh_pkg::status_type   status,
   output rnsh_pkg::cmd_type      cmd
);
   rnsh_pkg::state_type   state_ff, state_in;
   rnsh_pkg::div_sel_type sel_ff, sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_take;
   logic                  out_free;

   assign req_ready = (state_ff == rnsh_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rnsh_pkg::ST_IDLE: begin
            if (req_take && req_mode == rnsh_pkg::MODE_CAST) begin
               state_in = status.table_empty ? rnsh_pkg::ST_FIN_OUT : rnsh_pkg::ST_CAST_RD;
            end
         end
         rnsh_pkg::ST_CAST_RD:   state_in = rnsh_pkg::ST_CAST_SUB;
         rnsh_pkg::ST_CAST_SUB:  state_in = rnsh_pkg::ST_CAST_MUL;
         rnsh_pkg::ST_CAST_MUL:  state_in = rnsh_pkg::ST_CAST_NORM;
         rnsh_pkg::ST_CAST_NORM: state_in = rnsh_pkg::ST_CAST_PP;
         rnsh_pkg::ST_CAST_PP:   state_in = rnsh_pkg::ST_CAST_CMP;
         rnsh_pkg::ST_CAST_CMP: begin
            state_in = status.last_edge ? rnsh_pkg::ST_FIN_MUL : rnsh_pkg::ST_CAST_RD;
         end
         rnsh_pkg::ST_FIN_MUL: begin
            state_in = status.found ? rnsh_pkg::ST_FIN_LOAD : rnsh_pkg::ST_FIN_OUT;
         end
         rnsh_pkg::ST_FIN_LOAD:  state_in = rnsh_pkg::ST_FIN_RUN;
         rnsh_pkg::ST_FIN_RUN: begin
            if (status.div_last) begin
               state_in = rnsh_pkg::ST_FIN_STORE;
            end
         end
         rnsh_pkg::ST_FIN_STORE: begin
            state_in = (sel_ff == rnsh_pkg::SEL_T) ? rnsh_pkg::ST_FIN_OUT : rnsh_pkg::ST_FIN_MUL;
         end
         rnsh_pkg::ST_FIN_OUT: begin
            if (out_free) begin
               state_in = rnsh_pkg::ST_IDLE;
            end
         end
         default: state_in = rnsh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.sel         = sel_ff;
      sel_in          = sel_ff;
      cmd.load_edge   = req_take && req_mode == rnsh_pkg::MODE_LOAD;
      cmd.clear_table = req_take && req_mode == rnsh_pkg::MODE_CLEAR;
      cmd.load_ray    = req_take && req_mode == rnsh_pkg::MODE_CAST;
      case (state_ff)
         rnsh_pkg::ST_IDLE:      sel_in = rnsh_pkg::SEL_X;
         rnsh_pkg::ST_CAST_RD:   cmd.rd = 1'b1;
         rnsh_pkg::ST_CAST_SUB:  cmd.sub = 1'b1;
         rnsh_pkg::ST_CAST_MUL:  cmd.mul = 1'b1;
         rnsh_pkg::ST_CAST_NORM: cmd.norm = 1'b1;
         rnsh_pkg::ST_CAST_PP:   cmd.pp = 1'b1;
         rnsh_pkg::ST_CAST_CMP:  cmd.cmp = 1'b1;
         rnsh_pkg::ST_FIN_MUL:   cmd.fin_mul = 1'b1;
         rnsh_pkg::ST_FIN_LOAD:  cmd.fin_load = 1'b1;
         rnsh_pkg::ST_FIN_RUN:   cmd.fin_run = 1'b1;
         rnsh_pkg::ST_FIN_STORE: begin
            cmd.fin_store = 1'b1;
            case (sel_ff)
               rnsh_pkg::SEL_X: sel_in = rnsh_pkg::SEL_Y;
               rnsh_pkg::SEL_Y: sel_in = rnsh_pkg::SEL_T;
               default:         sel_in = rnsh_pkg::SEL_X;
            endcase
         end
         rnsh_pkg::ST_FIN_OUT:   cmd.out_load = out_free;
         default:                cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnsh_pkg::ST_IDLE;
         sel_ff       <= rnsh_pkg::SEL_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result not presented after output load");

   a_div_runs_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rnsh_pkg::ST_FIN_RUN && !status.div_last) |=>
      state_ff == rnsh_pkg::ST_FIN_RUN)
      else $error("division left before last step");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rnsh_pkg::ST_FIN_OUT && rsp_valid_ff && !rsp_ready) |=>
      state_ff == rnsh_pkg::ST_FIN_OUT)
      else $error("result overwritten while still pending");
endmodule

// File: hdl/rnsh_dp.sv
// Datapath: edge table, cross-product pipeline, exact nearest-t compare,
// shared restoring divider and result register. Depends on rnsh_pkg, rnsh_ram.
`timescale 1ns / 1ps
module rnsh_dp #(
   parameter int MaxEdges  = rnsh_pkg::MAX_EDGES_DEF,
   parameter int CoordBits = rnsh_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rnsh_pkg::IN_W-1:0]    req_start_x,
   input  logic signed [rnsh_pkg::IN_W-1:0]    req_start_y,
   input  logic signed [rnsh_pkg::IN_W-1:0]    req_dir_x,
   input  logic signed [rnsh_pkg::IN_W-1:0]    req_dir_y,
   input  rnsh_pkg::cmd_type                   cmd,
   output rnsh_pkg::status_type                status,
   output logic                                rsp_hit,
   output logic signed [rnsh_pkg::END_W-1:0]   rsp_end_x,
   output logic signed [rnsh_pkg::END_W-1:0]   rsp_end_y,
   output logic [rnsh_pkg::PARAM_W-1:0]        rsp_hit_param
);
   localparam int CB   = CoordBits;
   localparam int AW   = $clog2(MaxEdges);
   localparam int CW   = $clog2(MaxEdges + 1);
   localparam int EW   = 4 * CB;
   localparam int QB   = CB + 1;
   localparam int PW   = 2 * CB + 1;
   localparam int TW   = 2 * CB + 2;
   localparam int H    = TW / 2;
   localparam int CPW  = 2 * TW;
   localparam int MAGW = (3 * CB + 10 > 2 * CB + 19) ? 3 * CB + 10 : 2 * CB + 19;
   localparam int NW   = MAGW + 1;
   localparam int RW   = MAGW + 2;
   localparam int FPW  = CB + TW + 1;
   localparam int DW   = TW + 1;
   localparam int KW   = $clog2(MAGW);
   localparam int EO   = rnsh_pkg::END_W;
   localparam int PO   = rnsh_pkg::PARAM_W;

   function automatic logic signed [EO-1:0] sat_end(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] hi;
      logic signed [RW-1:0] lo;
      hi = RW'(rnsh_pkg::END_MAX);
      lo = RW'(rnsh_pkg::END_MIN);
      if (v > hi) begin
         return rnsh_pkg::END_MAX;
      end else if (v < lo) begin
         return rnsh_pkg::END_MIN;
      end
      return v[EO-1:0];
   endfunction

   // request coordinates wrapped to the coordinate width
   logic signed [CB-1:0] in_sx, in_sy, in_dx, in_dy;
   assign in_sx = CB'(req_start_x);
   assign in_sy = CB'(req_start_y);
   assign in_dx = CB'(req_dir_x);
   assign in_dy = CB'(req_dir_y);

   // table bookkeeping
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          full;
   logic          wr_en;
   logic [EW-1:0] rd_data;

   assign full  = (edge_count_ff == CW'(MaxEdges));
   assign wr_en = cmd.load_edge && !full;

   always_comb begin
      edge_count_in = edge_count_ff;
      if (cmd.clear_table) begin
         edge_count_in = '0;
      end else if (wr_en) begin
         edge_count_in = edge_count_ff + CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.load_ray) begin
         idx_in = '0;
      end else if (cmd.cmp) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   rnsh_ram #(
      .WIDTH (EW),
      .DEPTH (MaxEdges)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (edge_count_ff[AW-1:0]),
      .wr_data ({in_sx, in_sy, in_dx, in_dy}),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // ray registers
   logic signed [CB-1:0] px_ff, py_ff, rx_ff, ry_ff;

   // edge walk
   logic signed [CB-1:0] es_x, es_y, es_dx, es_dy;
   logic signed [QB-1:0] qx_ff, qy_ff;
   logic signed [CB-1:0] sx_ff, sy_ff;
   logic signed [PW-1:0] m_rs1_ff, m_rs2_ff, m_t1_ff, m_t2_ff, m_u1_ff, m_u2_ff;
   logic signed [TW-1:0] d_raw, tn_raw, un_raw, dn, tnn, unn;
   logic                 d_neg;
   logic                 cand_hit_ff;
   logic [TW-1:0]        cand_tn_ff, cand_d_ff;
   logic [TW-1:0]        best_tn_ff, best_d_ff;
   logic                 found_ff;
   logic [2*H-1:0]       pa_hh_ff, pa_hl_ff, pa_lh_ff, pa_ll_ff;
   logic [2*H-1:0]       pb_hh_ff, pb_hl_ff, pb_lh_ff, pb_ll_ff;
   logic [CPW-1:0]       lhs, rhs;
   logic                 take_cand;

   assign es_x  = rd_data[4*CB-1 -: CB];
   assign es_y  = rd_data[3*CB-1 -: CB];
   assign es_dx = rd_data[2*CB-1 -: CB];
   assign es_dy = rd_data[CB-1 -: CB];

   always_comb begin
      d_raw  = TW'(m_rs1_ff) - TW'(m_rs2_ff);
      tn_raw = TW'(m_t1_ff) - TW'(m_t2_ff);
      un_raw = TW'(m_u1_ff) - TW'(m_u2_ff);
      d_neg  = d_raw[TW-1];
      dn     = d_neg ? -d_raw : d_raw;
      tnn    = d_neg ? -tn_raw : tn_raw;
      unn    = d_neg ? -un_raw : un_raw;
   end

   assign lhs = (CPW'(pa_hh_ff) << (2 * H)) + (CPW'(pa_hl_ff) << H)
              + (CPW'(pa_lh_ff) << H) + CPW'(pa_ll_ff);
   assign rhs = (CPW'(pb_hh_ff) << (2 * H)) + (CPW'(pb_hl_ff) << H)
              + (CPW'(pb_lh_ff) << H) + CPW'(pb_ll_ff);
   assign take_cand = cmd.cmp && cand_hit_ff && (!found_ff || lhs < rhs);

   // final divisions
   logic signed [CB-1:0]  dir_sel;
   logic signed [TW:0]    tn_s, d_s;
   logic signed [FPW-1:0] fprod_ff;
   logic signed [NW-1:0]  n_sel, n2, n_abs;
   logic [MAGW-1:0]       div_num_ff;
   logic [DW-1:0]         div_den_ff, div_rem_ff;
   logic [DW:0]           rem_sh, rem_sub;
   logic                  div_ge;
   logic                  div_neg_ff;
   logic [KW-1:0]         div_cnt_ff;
   logic signed [RW-1:0]  q_s, q_r, v_x, v_y, tip_x, tip_y;
   logic signed [EO-1:0]  ex_ff, ey_ff;
   logic [PO-1:0]         t_ff;

   assign dir_sel = (cmd.sel == rnsh_pkg::SEL_Y) ? ry_ff : rx_ff;
   assign tn_s    = $signed({1'b0, best_tn_ff});
   assign d_s     = $signed({1'b0, best_d_ff});
   assign n_sel   = (cmd.sel == rnsh_pkg::SEL_T) ? (NW'(tn_s) <<< 16) : (NW'(fprod_ff) <<< 8);
   assign n2      = (n_sel <<< 1) + NW'(d_s);
   assign n_abs   = n2[NW-1] ? -n2 : n2;
   assign rem_sh  = {div_rem_ff, div_num_ff[MAGW-1]};
   assign div_ge  = rem_sh >= {1'b0, div_den_ff};
   assign rem_sub = rem_sh - {1'b0, div_den_ff};

   always_comb begin
      q_s = RW'($signed({1'b0, div_num_ff}));
      if (div_neg_ff) begin
         q_r = -(q_s + ((div_rem_ff != '0) ? RW'(1) : RW'(0)));
      end else begin
         q_r = q_s;
      end
      v_x   = (RW'(px_ff) <<< 8) + q_r;
      v_y   = (RW'(py_ff) <<< 8) + q_r;
      tip_x = (RW'(px_ff) + RW'(rx_ff)) <<< 8;
      tip_y = (RW'(py_ff) + RW'(ry_ff)) <<< 8;
   end

   // result register
   logic                 rsp_hit_ff;
   logic signed [EO-1:0] rsp_end_x_ff, rsp_end_y_ff;
   logic [PO-1:0]        rsp_hit_param_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
      end else begin
         edge_count_ff <= edge_count_in;
         idx_ff        <= idx_in;
         if (cmd.load_ray) begin
            found_ff <= 1'b0;
         end else if (take_cand) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ray) begin
         px_ff      <= in_sx;
         py_ff      <= in_sy;
         rx_ff      <= in_dx;
         ry_ff      <= in_dy;
         best_tn_ff <= '0;
         best_d_ff  <= TW'(1);
      end else if (take_cand) begin
         best_tn_ff <= cand_tn_ff;
         best_d_ff  <= cand_d_ff;
      end
      if (cmd.sub) begin
         qx_ff <= QB'(es_x) - QB'(px_ff);
         qy_ff <= QB'(es_y) - QB'(py_ff);
         sx_ff <= es_dx;
         sy_ff <= es_dy;
      end
      if (cmd.mul) begin
         m_rs1_ff <= PW'(rx_ff * sy_ff);
         m_rs2_ff <= PW'(ry_ff * sx_ff);
         m_t1_ff  <= PW'(qx_ff * sy_ff);
         m_t2_ff  <= PW'(qy_ff * sx_ff);
         m_u1_ff  <= PW'(qx_ff * ry_ff);
         m_u2_ff  <= PW'(qy_ff * rx_ff);
      end
      if (cmd.norm) begin
         cand_hit_ff <= (d_raw != '0) && !tnn[TW-1] && !unn[TW-1] && (unn <= dn);
         cand_tn_ff  <= tnn;
         cand_d_ff   <= dn;
      end
      if (cmd.pp) begin
         pa_hh_ff <= cand_tn_ff[TW-1:H] * best_d_ff[TW-1:H];
         pa_hl_ff <= cand_tn_ff[TW-1:H] * best_d_ff[H-1:0];
         pa_lh_ff <= cand_tn_ff[H-1:0] * best_d_ff[TW-1:H];
         pa_ll_ff <= cand_tn_ff[H-1:0] * best_d_ff[H-1:0];
         pb_hh_ff <= best_tn_ff[TW-1:H] * cand_d_ff[TW-1:H];
         pb_hl_ff <= best_tn_ff[TW-1:H] * cand_d_ff[H-1:0];
         pb_lh_ff <= best_tn_ff[H-1:0] * cand_d_ff[TW-1:H];
         pb_ll_ff <= best_tn_ff[H-1:0] * cand_d_ff[H-1:0];
      end
      if (cmd.fin_mul) begin
         fprod_ff <= FPW'(dir_sel * tn_s);
      end
      if (cmd.fin_load) begin
         div_num_ff <= n_abs[MAGW-1:0];
         div_den_ff <= {best_d_ff, 1'b0};
         div_rem_ff <= '0;
         div_neg_ff <= n2[NW-1];
         div_cnt_ff <= '0;
      end else if (cmd.fin_run) begin
         div_rem_ff <= div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         div_num_ff <= {div_num_ff[MAGW-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + KW'(1);
      end
      if (cmd.fin_store) begin
         case (cmd.sel)
            rnsh_pkg::SEL_X: ex_ff <= sat_end(v_x);
            rnsh_pkg::SEL_Y: ey_ff <= sat_end(v_y);
            default: begin
               t_ff <= (div_num_ff > MAGW'(32'hFFFF_FFFF)) ? '1 : div_num_ff[PO-1:0];
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_hit_ff       <= found_ff;
         rsp_end_x_ff     <= found_ff ? ex_ff : sat_end(tip_x);
         rsp_end_y_ff     <= found_ff ? ey_ff : sat_end(tip_y);
         rsp_hit_param_ff <= found_ff ? t_ff : rnsh_pkg::T_ONE;
      end
   end

   assign status.table_empty = (edge_count_ff == '0);
   assign status.last_edge   = (idx_ff == edge_count_ff - CW'(1));
   assign status.found       = found_ff;
   assign status.div_last    = (div_cnt_ff == KW'(MAGW - 1));

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_end_x     = rsp_end_x_ff;
   assign rsp_end_y     = rsp_end_y_ff;
   assign rsp_hit_param = rsp_hit_param_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= CW'(MaxEdges))
      else $error("edge count beyond table depth");

   a_best_den: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_d_ff != '0)
      else $error("nearest hit held with zero denominator");
endmodule

// File: hdl/ray_nearest_segment_hit_top.sv
// Nearest ray/segment hit. Load, clear and unused-mode requests finish on acceptance.
// A cast over N stored edges walks each edge through RAM read, subtract, cross
// products, sign fold, split compare products and compare. With an empty table the cast
// goes straight to the result load; with no hit the result loads after the walk; with a
// hit, after three restoring divisions (x, y and t). One request at a time; the next is
// taken in the cycle after the result loads. Synchronous reset empties the table.
`timescale 1ns / 1ps
module ray_nearest_segment_hit_top #(
   parameter int MaxEdges  = rnsh_pkg::MAX_EDGES_DEF,
   parameter int CoordBits = rnsh_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rnsh_req_if.sink   req_chan,
   rnsh_rsp_if.source rsp_chan
);
   rnsh_pkg::cmd_type    cmd;
   rnsh_pkg::status_type status;

   rnsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rnsh_dp #(
      .MaxEdges  (MaxEdges),
      .CoordBits (CoordBits)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_start_x   (req_chan.start_x),
      .req_start_y   (req_chan.start_y),
      .req_dir_x     (req_chan.dir_x),
      .req_dir_y     (req_chan.dir_y),
      .cmd           (cmd),
      .status        (status),
      .rsp_hit       (rsp_chan.hit),
      .rsp_end_x     (rsp_chan.end_x),
      .rsp_end_y     (rsp_chan.end_y),
      .rsp_hit_param (rsp_chan.hit_param)
   );
endmodule
